// ----- hdl/strongly_connected_components_assert.svh -----
// Assertion macros shared by the strongly connected components design.
`ifndef STRONGLY_CONNECTED_COMPONENTS_ASSERT_SVH
`define STRONGLY_CONNECTED_COMPONENTS_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SCC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCC_ASSERT(lbl, clk, rst, prop, msg)
`define SCC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- hdl/scc_pkg.sv -----
// Package with constants, codes and command/status types of the component search.
package scc_pkg;
  localparam int MAX_VERTICES = 32;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = VW + 1;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_EDGE   = 2'd1;
  localparam logic [1:0] MODE_RUN    = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic clear;
    logic add_edge;
    logic start_run;
    logic scan_step;
    logic enter_w;
    logic enter_r;
    logic low_upd;
    logic pop_start;
    logic pop_one;
    logic ret_root;
    logic restore;
    logic r_inc;
    logic i_inc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic w_ge_n;
    logic adj_bit;
    logic vis_w;
    logic onstk_w;
    logic low_eq;
    logic pop_end;
    logic fc_one;
    logic r_ge_n;
    logic vis_r;
    logic i_ge_n;
    logic leader_i;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [VW-1:0] v;
    logic [CW-1:0] w;
    logic [CW-1:0] low;
    logic [CW-1:0] ord;
  } frame_t;
endpackage

// ----- hdl/scc_if.sv -----
// Handshake channel interfaces for input items and result items.
interface scc_in_if;
  import scc_pkg::*;
  logic          valid;
  logic          ready;
  logic [1:0]    mode;
  logic [VW-1:0] source_vertex;
  logic [VW-1:0] target_vertex;
  modport source (output valid, mode, source_vertex, target_vertex, input ready);
  modport sink (input valid, mode, source_vertex, target_vertex, output ready);
endinterface

interface scc_out_if;
  import scc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [MAX_VERTICES-1:0] member_mask;
  logic                    last_component;
  modport source (output valid, member_mask, last_component, input ready);
  modport sink (input valid, member_mask, last_component, output ready);
endinterface

// ----- hdl/scc_ctrl.sv -----
// Controller state machine sequencing clear, edge load, search and emission.
module scc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [1:0]    in_mode,
  output logic          in_ready,
  input  scc_pkg::sts_t sts,
  output scc_pkg::cmd_t cmd
);
  import scc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ROOT = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_LOWCHK = 4'd3;
  localparam logic [3:0] S_POPRD = 4'd4;
  localparam logic [3:0] S_POP = 4'd5;
  localparam logic [3:0] S_RET = 4'd6;
  localparam logic [3:0] S_FRD = 4'd7;
  localparam logic [3:0] S_REST = 4'd8;
  localparam logic [3:0] S_ERD = 4'd9;
  localparam logic [3:0] S_EOUT = 4'd10;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == MODE_CLEAR) cmd.clear = 1'b1;
          if (in_mode == MODE_EDGE) cmd.add_edge = 1'b1;
          if (in_mode == MODE_RUN) begin
            cmd.start_run = 1'b1;
            state_next = S_ROOT;
          end
        end
      end
      S_ROOT: begin
        priority if (sts.r_ge_n) begin
          state_next = S_ERD;
        end else if (sts.vis_r) begin
          cmd.r_inc = 1'b1;
        end else begin
          cmd.enter_r = 1'b1;
          cmd.r_inc = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.w_ge_n) begin
          if (sts.low_eq) begin
            cmd.pop_start = 1'b1;
            state_next = S_POPRD;
          end else begin
            state_next = S_RET;
          end
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.adj_bit) begin
            if (!sts.vis_w) cmd.enter_w = 1'b1;
            else if (sts.onstk_w) state_next = S_LOWCHK;
          end
        end
      end
      S_LOWCHK: begin
        cmd.low_upd = 1'b1;
        state_next = S_SCAN;
      end
      S_POPRD: state_next = S_POP;
      S_POP: begin
        cmd.pop_one = 1'b1;
        state_next = sts.pop_end ? S_RET : S_POPRD;
      end
      S_RET: begin
        if (sts.fc_one) begin
          cmd.ret_root = 1'b1;
          state_next = S_ROOT;
        end else begin
          state_next = S_FRD;
        end
      end
      S_FRD: state_next = S_REST;
      S_REST: begin
        cmd.restore = 1'b1;
        state_next = S_SCAN;
      end
      S_ERD: state_next = S_EOUT;
      S_EOUT: begin
        if (sts.i_ge_n) begin
          state_next = S_IDLE;
        end else if (!sts.leader_i) begin
          cmd.i_inc = 1'b1;
          state_next = S_ERD;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.i_inc = 1'b1;
          state_next = S_ERD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ----- hdl/scc_dp.sv -----
// Datapath: adjacency matrix, search stacks, per-vertex memories and output register.
module scc_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [scc_pkg::CW-1:0]         cfg_wdata,
  input  logic [scc_pkg::VW-1:0]         src,
  input  logic [scc_pkg::VW-1:0]         dst,
  input  scc_pkg::cmd_t                  cmd,
  output scc_pkg::sts_t                  sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [scc_pkg::MAX_VERTICES-1:0] out_mask,
  output logic                           out_last
);
  import scc_pkg::*;
  `include "strongly_connected_components_assert.svh"

  logic [CW-1:0]           vcount;
  logic [CW-1:0]           n;
  logic [MAX_VERTICES-1:0] adj [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] vis, onstk, leader;
  logic [CW-1:0]           cnt, sp, fc, r, i;
  logic [VW-1:0]           cur_v;
  logic [CW-1:0]           cur_w, cur_low, cur_ord;
  logic [MAX_VERTICES-1:0] pmask;
  logic [VW-1:0]           pmin;

  logic [CW-1:0]           order_mem [MAX_VERTICES];
  frame_t                  frame_mem [MAX_VERTICES];
  logic [VW-1:0]           cst_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] mask_mem [MAX_VERTICES];
  logic [CW-1:0]           order_q;
  frame_t                  frame_q;
  logic [VW-1:0]           cst_q;
  logic [MAX_VERTICES-1:0] mask_q;

  logic                    entering;
  logic [VW-1:0]           ent_x;
  logic [MAX_VERTICES-1:0] pmask_n;
  logic [VW-1:0]           pmin_n;
  logic [MAX_VERTICES-1:0] above_i;
  frame_t                  push_f;

  assign n = (vcount > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vcount;
  assign entering = cmd.enter_w | cmd.enter_r;
  assign ent_x = cmd.enter_r ? r[VW-1:0] : cur_w[VW-1:0];
  assign pmask_n = pmask | (MAX_VERTICES'(1) << cst_q);
  assign pmin_n = (cst_q < pmin) ? cst_q : pmin;
  assign above_i = (leader >> i[VW-1:0]) >> 1;
  assign push_f = '{v: cur_v, w: cur_w + CW'(1), low: cur_low, ord: cur_ord};

  always_comb begin
    sts.w_ge_n = cur_w >= n;
    sts.adj_bit = adj[cur_v][cur_w[VW-1:0]];
    sts.vis_w = vis[cur_w[VW-1:0]];
    sts.onstk_w = onstk[cur_w[VW-1:0]];
    sts.low_eq = cur_low == cur_ord;
    sts.pop_end = (cst_q == cur_v) || (sp == CW'(1));
    sts.fc_one = fc == CW'(1);
    sts.r_ge_n = r >= n;
    sts.vis_r = vis[r[VW-1:0]];
    sts.i_ge_n = i >= n;
    sts.leader_i = leader[i[VW-1:0]];
    sts.out_free = !out_valid || out_ready;
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= CW'(MAX_VERTICES);
      for (int k = 0; k < MAX_VERTICES; k++) adj[k] <= '0;
      vis <= '0;
      onstk <= '0;
      leader <= '0;
      cnt <= '0;
      sp <= '0;
      fc <= '0;
      r <= '0;
      i <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) vcount <= cfg_wdata;
      if (cmd.clear) begin
        for (int k = 0; k < MAX_VERTICES; k++) adj[k] <= '0;
      end
      if (cmd.add_edge) adj[src][dst] <= 1'b1;
      if (cmd.start_run) begin
        vis <= '0;
        onstk <= '0;
        leader <= '0;
        cnt <= '0;
        sp <= '0;
        fc <= '0;
        r <= '0;
        i <= '0;
      end
      if (entering) begin
        vis[ent_x] <= 1'b1;
        onstk[ent_x] <= 1'b1;
        sp <= sp + CW'(1);
        cnt <= cnt + CW'(1);
        fc <= cmd.enter_r ? CW'(1) : fc + CW'(1);
      end
      if (cmd.pop_one) begin
        onstk[cst_q] <= 1'b0;
        sp <= sp - CW'(1);
        if (sts.pop_end) leader[pmin_n] <= 1'b1;
      end
      if (cmd.ret_root) fc <= '0;
      if (cmd.restore) fc <= fc - CW'(1);
      if (cmd.r_inc) r <= r + CW'(1);
      if (cmd.i_inc) i <= i + CW'(1);
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.emit) out_valid <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.scan_step) cur_w <= cur_w + CW'(1);
    if (entering) begin
      cur_v <= ent_x;
      cur_w <= '0;
      cur_low <= cnt;
      cur_ord <= cnt;
    end
    if (cmd.low_upd && order_q < cur_low) cur_low <= order_q;
    if (cmd.pop_start) begin
      pmask <= '0;
      pmin <= '1;
    end
    if (cmd.pop_one) begin
      pmask <= pmask_n;
      pmin <= pmin_n;
    end
    if (cmd.restore) begin
      cur_v <= frame_q.v;
      cur_w <= frame_q.w;
      cur_ord <= frame_q.ord;
      cur_low <= (cur_low < frame_q.low) ? cur_low : frame_q.low;
    end
    if (cmd.emit) begin
      out_mask <= mask_q;
      out_last <= above_i == '0;
    end
  end

  // Memories, one write and one registered read each.
  always_ff @(posedge clk) begin
    if (entering) begin
      order_mem[ent_x] <= cnt;
      cst_mem[sp[VW-1:0]] <= ent_x;
    end
    if (cmd.enter_w) frame_mem[VW'(fc - CW'(1))] <= push_f;
    if (cmd.pop_one && sts.pop_end) mask_mem[pmin_n] <= pmask_n;
    order_q <= order_mem[cur_w[VW-1:0]];
    frame_q <= frame_mem[VW'(fc - CW'(2))];
    cst_q <= cst_mem[VW'(sp - CW'(1))];
    mask_q <= mask_mem[i[VW-1:0]];
  end

  // Once a component is popped, its root frame stays counted until the return step.
  `SCC_ASSERT(a_stack_count, clk, rst, $countones(onstk) == 32'(sp), "stack depth mismatch")
  `SCC_ASSERT(a_onstk_visited, clk, rst, (onstk & ~vis) == '0, "stacked vertex not visited")
  `SCC_ASSERT_ALWAYS(a_frames_le_stack, clk, rst || fc <= sp + CW'(1), "too many frames")
endmodule

// ----- hdl/strongly_connected_components.sv -----
// Top level of the strongly connected component search block.
//
//  channel | direction | fields                                 | handshake
//  req     | in        | mode, source_vertex, target_vertex     | valid/ready
//  rsp     | out       | member_mask, last_component            | valid/ready
//  cfg     | in        | cfg_wdata (vertex_count)               | cfg_we only
//
// A clear or an edge item is taken as soon as it is offered while idle. A run item
// holds the input off until the depth first scan and the emission scan are done. The
// depth first scan tests one adjacency bit per cycle, but pauses for pops, returns and
// for a low-link update on each edge that leads back to a vertex still on the stack.
// Reset is synchronous and clears the adjacency matrix and all control state.
// Results wait in an output register; the emission scan pauses while it is full.
module strongly_connected_components (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [scc_pkg::CW-1:0] cfg_wdata,
  scc_in_if.sink                 req,
  scc_out_if.source              rsp
);
  import scc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller sees only status bits and the mode of the offered item.
  scc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_mode  (req.mode),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the graph, the search state and the result register.
  scc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .src       (req.source_vertex),
    .dst       (req.target_vertex),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_mask  (rsp.member_mask),
    .out_last  (rsp.last_component)
  );
endmodule
